@@ sv/bst_pkg.sv @@
// Shared constants, codes and types of the BSSID table.
package bst_pkg;

   localparam int TABLE_SLOTS = 32;
   localparam int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);

   localparam int CMD_W   = 2;
   localparam int KEY_W   = 48;
   localparam int CHAN_W  = 4;
   localparam int MASK_W  = 16;
   localparam int RSSI_W  = 8;
   localparam int LIFE_W  = 4;
   localparam int SLOT_W  = 5;
   localparam int STAT_W  = 3;
   localparam int COUNT_W = 6;

   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;

   localparam logic [LIFE_W-1:0] RELOAD_RESET = 4'd3;
   localparam logic [0:0] REG_LIFETIME_RELOAD = 1'b0;

   typedef enum logic [CMD_W-1:0] {
      CMD_OBSERVE     = 2'd0,
      CMD_BEGIN_SWEEP = 2'd1,
      CMD_END_SWEEP   = 2'd2,
      CMD_READ        = 2'd3
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STATUS_MERGED     = 3'd0,
      STATUS_INSERTED   = 3'd1,
      STATUS_FULL       = 3'd2,
      STATUS_SWEEP_DONE = 3'd3,
      STATUS_EMPTY      = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_APPLY,
      ST_PURGE,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_LOOK,
      OP_APPLY,
      OP_SHIFT
   } cell_op_type;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      cell_op_type              op;
      cmd_type                  cmd;
      logic                     any_hit;
      logic [KEY_W-1:0]         key;
      logic [MASK_W-1:0]        bitmask;
      logic signed [RSSI_W-1:0] rssi;
      logic [LIFE_W-1:0]        reload;
      logic [SLOT_W-1:0]        read_slot;
   } cell_ctrl_type;

   // slot contents collected along the row, one cell ORs in its own
   typedef struct packed {
      logic                valid;
      logic [IDX_W-1:0]    index;
      logic [KEY_W-1:0]    key;
      logic [MASK_W-1:0]   channels;
      logic [RSSI_W-1:0]   strength;
      logic [LIFE_W-1:0]   lifetime;
   } cell_data_type;

endpackage

@@ sv/bst_if.sv @@
// Request and response channel interfaces of the BSSID table.
interface bst_req_if;
   import bst_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         command;
   logic [KEY_W-1:0]         bssid;
   logic [CHAN_W-1:0]        channel;
   logic signed [RSSI_W-1:0] rssi;
   logic [SLOT_W-1:0]        read_slot;

   modport source (output valid, command, bssid, channel, rssi, read_slot, input ready);
   modport sink (input valid, command, bssid, channel, rssi, read_slot, output ready);
endinterface

interface bst_rsp_if;
   import bst_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [STAT_W-1:0]        status;
   logic [SLOT_W-1:0]        slot_index;
   logic [KEY_W-1:0]         entry_key;
   logic [MASK_W-1:0]        entry_channels;
   logic signed [RSSI_W-1:0] entry_strength;
   logic [LIFE_W-1:0]        entry_lifetime;
   logic [COUNT_W-1:0]       entry_count;

   modport source (output valid, status, slot_index, entry_key, entry_channels,
                   entry_strength, entry_lifetime, entry_count, input ready);
   modport sink (input valid, status, slot_index, entry_key, entry_channels,
                 entry_strength, entry_lifetime, entry_count, output ready);
endinterface

@@ sv/bst_cell.sv @@
// One table slot: key compare, merge, aging and purge shift stage.
module bst_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  bst_pkg::cell_ctrl_type ctrl,
   input  logic [bst_pkg::IDX_W-1:0] index,
   input  logic                   hit_before,
   input  logic                   free_before,
   output logic                   hit_after,
   output logic                   free_after,
   input  logic                   purge_prev,
   output logic                   purge_next,
   input  bst_pkg::cell_data_type data_prev,
   output bst_pkg::cell_data_type data_next
);
   import bst_pkg::*;

   logic valid_ff, valid_in;
   logic expiring_ff, expiring_in;
   logic purge_ff, purge_in;
   logic match_ff, match_in;
   logic free_ff, free_in;
   logic sel_ff, sel_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [MASK_W-1:0] chan_ff, chan_in;
   logic [RSSI_W-1:0] strength_ff, strength_in;
   logic [LIFE_W-1:0] life_ff, life_in;

   logic hit_first;
   logic free_first;

   assign hit_first  = match_ff & ~hit_before;
   assign free_first = free_ff & ~free_before;
   assign hit_after  = hit_before | match_ff;
   assign free_after = free_before | free_ff;
   assign purge_next = purge_ff;

   always_comb begin
      valid_in    = valid_ff;
      expiring_in = expiring_ff;
      purge_in    = purge_ff;
      match_in    = match_ff;
      free_in     = free_ff;
      sel_in      = sel_ff;
      key_in      = key_ff;
      chan_in     = chan_ff;
      strength_in = strength_ff;
      life_in     = life_ff;
      case (ctrl.op)
         OP_LOOK: begin
            match_in = valid_ff && (key_ff == ctrl.key);
            free_in  = ~valid_ff;
         end
         OP_APPLY: begin
            case (ctrl.cmd)
               CMD_OBSERVE: begin
                  sel_in = hit_first | (free_first & ~ctrl.any_hit);
                  if (hit_first) begin
                     if (life_ff == ctrl.reload) begin
                        chan_in = chan_ff | ctrl.bitmask;
                        if ($signed(strength_ff) > ctrl.rssi) begin
                           strength_in = ctrl.rssi;
                        end
                     end else begin
                        chan_in     = ctrl.bitmask;
                        strength_in = ctrl.rssi;
                        life_in     = ctrl.reload;
                     end
                  end else if (free_first && !ctrl.any_hit) begin
                     valid_in    = 1'b1;
                     expiring_in = 1'b0;
                     key_in      = ctrl.key;
                     chan_in     = ctrl.bitmask;
                     strength_in = ctrl.rssi;
                     life_in     = ctrl.reload;
                  end
               end
               CMD_BEGIN_SWEEP: begin
                  sel_in = 1'b0;
                  if (!valid_ff) begin
                     expiring_in = 1'b0;
                  end else if (life_ff == '0) begin
                     expiring_in = 1'b1;
                  end else begin
                     expiring_in = 1'b0;
                     life_in     = life_ff - LIFE_W'(1);
                  end
               end
               CMD_END_SWEEP: begin
                  sel_in      = 1'b0;
                  purge_in    = valid_ff & expiring_ff;
                  expiring_in = 1'b0;
                  if (valid_ff && expiring_ff) begin
                     valid_in = 1'b0;
                  end
               end
               CMD_READ: begin
                  sel_in = (9'(index) == 9'(ctrl.read_slot));
               end
               default: begin
                  sel_in = 1'b0;
               end
            endcase
         end
         OP_SHIFT: begin
            purge_in = purge_prev;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         expiring_ff <= 1'b0;
         purge_ff    <= 1'b0;
         match_ff    <= 1'b0;
         free_ff     <= 1'b0;
         sel_ff      <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         expiring_ff <= expiring_in;
         purge_ff    <= purge_in;
         match_ff    <= match_in;
         free_ff     <= free_in;
         sel_ff      <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      chan_ff     <= chan_in;
      strength_ff <= strength_in;
      life_ff     <= life_in;
   end

   // merge the selected valid slot into the word passed along the row
   always_comb begin
      data_next = data_prev;
      if (sel_ff && valid_ff) begin
         data_next.valid    = 1'b1;
         data_next.index    = data_prev.index | index;
         data_next.key      = data_prev.key | key_ff;
         data_next.channels = data_prev.channels | chan_ff;
         data_next.strength = data_prev.strength | strength_ff;
         data_next.lifetime = data_prev.lifetime | life_ff;
      end
   end

endmodule

@@ sv/bst_csr.sv @@
// Configuration register file of the BSSID table on an APB-style port.
module bst_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [bst_pkg::ADDR_W-1:0] paddr,
   input  logic [bst_pkg::DATA_W-1:0] pwdata,
   output logic [bst_pkg::DATA_W-1:0] prdata,
   output logic                       pready,
   output logic [bst_pkg::LIFE_W-1:0] lifetime_reload
);
   import bst_pkg::*;

   logic [LIFE_W-1:0] reload_ff, reload_in;
   logic [0:0]        reg_index;

   assign reg_index = paddr[ADDR_W-1];
   assign pready    = 1'b1;

   always_comb begin
      reload_in = reload_ff;
      if (psel && penable && pwrite && (reg_index == REG_LIFETIME_RELOAD)) begin
         reload_in = pwdata[LIFE_W-1:0];
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_LIFETIME_RELOAD: prdata = DATA_W'(reload_ff);
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff <= RELOAD_RESET;
      end else begin
         reload_ff <= reload_in;
      end
   end

   assign lifetime_reload = reload_ff;

endmodule

@@ sv/bssid_table_with_aging.sv @@
// Top level of the BSSID table with aging: sequencer, cell row and result register.
//
// The req channel carries one command word (observe, begin sweep, end sweep,
// read slot); the rsp channel returns exactly one result word per command.
// The table is a row of TABLE_SLOTS cells, each holding one entry; the cells
// compare the key in parallel and pass hit, free, purge and read data along
// the row to their neighbors.
// Observe, begin sweep and read raise rsp.valid after the states look (key
// compare per cell), apply (first hit or first free slot along the row) and out
// (selected slot collected along the row into the output register); idle then
// accepts the next word. End sweep adds a purge state between apply and out: the
// purge marks shift out of the last cell one per cycle to update the entry count.
// One command is in work at a time; req.ready is high while the sequencer is
// idle, even when an earlier result still waits in the output register.
// If the receiver stalls, the result is held and a finished command waits in
// the out state until the register frees up.
// Reset empties the table (valid and expiring marks cleared at once, count 0) and
// loads lifetime_reload with 3; the block is ready once reset is released. The user
// writes lifetime_reload over the APB port only while idle, unchecked by the block.
module bssid_table_with_aging (
   input  logic                       clock,
   input  logic                       reset,
   bst_req_if.sink                    req,
   bst_rsp_if.source                  rsp,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [bst_pkg::ADDR_W-1:0] paddr,
   input  logic [bst_pkg::DATA_W-1:0] pwdata,
   output logic [bst_pkg::DATA_W-1:0] prdata,
   output logic                       pready
);
   import bst_pkg::*;

   // sequencer state and latched command word
   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [MASK_W-1:0] bitmask_ff, bitmask_in;
   logic [RSSI_W-1:0] rssi_ff, rssi_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   status_type        status_ff, status_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  purge_cnt_ff, purge_cnt_in;

   // output register
   logic               out_valid_ff, out_valid_in;
   logic [STAT_W-1:0]  out_status_ff, out_status_in;
   logic [SLOT_W-1:0]  out_slot_ff, out_slot_in;
   logic [KEY_W-1:0]   out_key_ff, out_key_in;
   logic [MASK_W-1:0]  out_chan_ff, out_chan_in;
   logic [RSSI_W-1:0]  out_strength_ff, out_strength_in;
   logic [LIFE_W-1:0]  out_life_ff, out_life_in;
   logic [COUNT_W-1:0] out_count_ff, out_count_in;

   logic [LIFE_W-1:0] lifetime_reload;
   cell_ctrl_type     ctrl;
   cell_op_type       cell_op;
   logic              accept;
   logic              out_free;
   logic              any_hit;
   logic              any_free;
   logic              purge_last;
   logic [15:0]       idx_wide;
   logic [15:0]       count_wide;

   logic [TABLE_SLOTS:0] hit_chain;
   logic [TABLE_SLOTS:0] free_chain;
   logic [TABLE_SLOTS:0] purge_chain;
   cell_data_type        data_chain [TABLE_SLOTS+1];

   bst_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .lifetime_reload (lifetime_reload)
   );

   // row of cells; the head of every chain starts empty
   assign hit_chain[0]   = 1'b0;
   assign free_chain[0]  = 1'b0;
   assign purge_chain[0] = 1'b0;
   assign data_chain[0]  = '0;

   for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
      bst_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .index       (IDX_W'(i)),
         .hit_before  (hit_chain[i]),
         .free_before (free_chain[i]),
         .hit_after   (hit_chain[i+1]),
         .free_after  (free_chain[i+1]),
         .purge_prev  (purge_chain[i]),
         .purge_next  (purge_chain[i+1]),
         .data_prev   (data_chain[i]),
         .data_next   (data_chain[i+1])
      );
   end

   assign any_hit    = hit_chain[TABLE_SLOTS];
   assign any_free   = free_chain[TABLE_SLOTS];
   assign purge_last = purge_chain[TABLE_SLOTS];

   assign out_free = ~out_valid_ff | rsp.ready;
   assign accept   = req.valid & req.ready;

   // broadcast to the row
   always_comb begin
      ctrl.op        = cell_op;
      ctrl.cmd       = cmd_ff;
      ctrl.any_hit   = any_hit;
      ctrl.key       = key_ff;
      ctrl.bitmask   = bitmask_ff;
      ctrl.rssi      = rssi_ff;
      ctrl.reload    = lifetime_reload;
      ctrl.read_slot = slot_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req.valid) state_in = ST_LOOK;
         ST_LOOK:  state_in = ST_APPLY;
         ST_APPLY: state_in = (cmd_ff == CMD_END_SWEEP) ? ST_PURGE : ST_OUT;
         ST_PURGE: if (purge_cnt_ff == IDX_W'(TABLE_SLOTS - 1)) state_in = ST_OUT;
         ST_OUT:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs; hold off the req channel while reset is applied
   always_comb begin
      req.ready = 1'b0;
      cell_op   = OP_HOLD;
      unique case (state_ff)
         ST_IDLE:  req.ready = ~reset;
         ST_LOOK:  cell_op = OP_LOOK;
         ST_APPLY: cell_op = OP_APPLY;
         ST_PURGE: cell_op = OP_SHIFT;
         ST_OUT:   cell_op = OP_HOLD;
         default:  cell_op = OP_HOLD;
      endcase
   end

   // latch the command word, settle status and entry count
   always_comb begin
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      bitmask_in   = bitmask_ff;
      rssi_in      = rssi_ff;
      slot_in      = slot_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      purge_cnt_in = purge_cnt_ff;
      if (accept) begin
         cmd_in     = cmd_type'(req.command);
         key_in     = req.bssid;
         bitmask_in = MASK_W'(1) << req.channel;
         rssi_in    = req.rssi;
         slot_in    = req.read_slot;
      end
      if (state_ff == ST_APPLY) begin
         purge_cnt_in = '0;
         case (cmd_ff) inside
            CMD_OBSERVE: begin
               if (any_hit) begin
                  status_in = STATUS_MERGED;
               end else if (any_free) begin
                  status_in = STATUS_INSERTED;
                  count_in  = count_ff + CNT_W'(1);
               end else begin
                  status_in = STATUS_FULL;
               end
            end
            CMD_BEGIN_SWEEP, CMD_END_SWEEP: status_in = STATUS_SWEEP_DONE;
            default:                        status_in = STATUS_MERGED;
         endcase
      end
      if (state_ff == ST_PURGE) begin
         // count each purge mark as it leaves the end of the row
         purge_cnt_in = purge_cnt_ff + IDX_W'(1);
         if (purge_last) begin
            count_in = count_ff - CNT_W'(1);
         end
      end
   end

   assign idx_wide   = 16'(data_chain[TABLE_SLOTS].index);
   assign count_wide = 16'(count_ff);

   // load the result word from the data collected along the row
   always_comb begin
      out_valid_in    = out_valid_ff & ~rsp.ready;
      out_status_in   = out_status_ff;
      out_slot_in     = out_slot_ff;
      out_key_in      = out_key_ff;
      out_chan_in     = out_chan_ff;
      out_strength_in = out_strength_ff;
      out_life_in     = out_life_ff;
      out_count_in    = out_count_ff;
      if (state_ff == ST_OUT && out_free) begin
         out_valid_in    = 1'b1;
         out_key_in      = data_chain[TABLE_SLOTS].key;
         out_chan_in     = data_chain[TABLE_SLOTS].channels;
         out_strength_in = data_chain[TABLE_SLOTS].strength;
         out_life_in     = data_chain[TABLE_SLOTS].lifetime;
         out_count_in    = count_wide[COUNT_W-1:0];
         if (cmd_ff == CMD_READ) begin
            out_slot_in   = slot_ff;
            out_status_in = data_chain[TABLE_SLOTS].valid ? STATUS_MERGED : STATUS_EMPTY;
         end else begin
            out_slot_in   = idx_wide[SLOT_W-1:0];
            out_status_in = status_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff          <= cmd_in;
      key_ff          <= key_in;
      bitmask_ff      <= bitmask_in;
      rssi_ff         <= rssi_in;
      slot_ff         <= slot_in;
      status_ff       <= status_in;
      purge_cnt_ff    <= purge_cnt_in;
      out_status_ff   <= out_status_in;
      out_slot_ff     <= out_slot_in;
      out_key_ff      <= out_key_in;
      out_chan_ff     <= out_chan_in;
      out_strength_ff <= out_strength_in;
      out_life_ff     <= out_life_in;
      out_count_ff    <= out_count_in;
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.status         = out_status_ff;
   assign rsp.slot_index     = out_slot_ff;
   assign rsp.entry_key      = out_key_ff;
   assign rsp.entry_channels = out_chan_ff;
   assign rsp.entry_strength = out_strength_ff;
   assign rsp.entry_lifetime = out_life_ff;
   assign rsp.entry_count    = out_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_SLOTS))
      else $error("entry count above table size");

   a_accept_look: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_LOOK)
      else $error("accepted word did not start a lookup");

   a_end_sweep_purge: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY && cmd_ff == CMD_END_SWEEP) |=> state_ff == ST_PURGE)
      else $error("end sweep skipped the purge shift");

   a_result_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("result word loaded outside the out state");

endmodule

@@ test/bssid_table_with_aging_test.sv @@
// Self-checking testbench of the BSSID table with aging: directed cases, then random traffic.
module bssid_table_with_aging_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bst_pkg::*;

   // one command word as it goes over the req channel
   typedef struct packed {
      cmd_type                  command;
      logic [KEY_W-1:0]         bssid;
      logic [CHAN_W-1:0]        channel;
      logic signed [RSSI_W-1:0] rssi;
      logic [SLOT_W-1:0]        read_slot;
   } scan_word_type;

   // one result word as it comes back over the rsp channel
   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic [SLOT_W-1:0]        slot_index;
      logic [KEY_W-1:0]         entry_key;
      logic [MASK_W-1:0]        entry_channels;
      logic signed [RSSI_W-1:0] entry_strength;
      logic [LIFE_W-1:0]        entry_lifetime;
      logic [COUNT_W-1:0]       entry_count;
   } table_reply_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   bst_req_if req_ch ();
   bst_rsp_if rsp_ch ();

   bssid_table_with_aging dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Shadow of the table, kept in step with every accepted word.
   logic                     slot_used   [TABLE_SLOTS];
   logic [KEY_W-1:0]         slot_bssid  [TABLE_SLOTS];
   logic [MASK_W-1:0]        slot_mask   [TABLE_SLOTS];
   logic signed [RSSI_W-1:0] slot_rssi   [TABLE_SLOTS];
   logic [LIFE_W-1:0]        slot_life   [TABLE_SLOTS];
   logic                     slot_marked [TABLE_SLOTS];
   int                       live_entries;
   logic [LIFE_W-1:0]        reload_val;

   table_reply_type  pending_replies [$];
   logic [KEY_W-1:0] key_pool [$];
   int               mismatches = 0;
   int               gap_odds   = 4;   // 1 in gap_odds words starts a sender gap, 0 = never
   int               stall_odds = 4;   // same for receiver stalls
   int               stall_left = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Apply one word to the shadow table and return the result word it must produce.
   function automatic table_reply_type apply_scan_word(scan_word_type w);
      table_reply_type   r;
      status_type        st;
      int                sel;
      int                hit;
      int                free_slot;
      logic [MASK_W-1:0] chan_bit;
      r         = '0;
      st        = STATUS_SWEEP_DONE;
      sel       = -1;
      hit       = -1;
      free_slot = -1;
      chan_bit  = MASK_W'(1) << w.channel;
      case (w.command)
         CMD_OBSERVE: begin
            // first matching valid slot wins; otherwise remember the lowest free one
            for (int i = 0; i < TABLE_SLOTS; i++) begin
               if (slot_used[i]) begin
                  if (hit < 0 && slot_bssid[i] == w.bssid) hit = i;
               end else if (free_slot < 0) begin
                  free_slot = i;
               end
            end
            if (hit >= 0) begin
               if (slot_life[hit] == reload_val) begin
                  // already seen this sweep: merge channel, keep the weaker level
                  slot_mask[hit] = slot_mask[hit] | chan_bit;
                  if ($signed(slot_rssi[hit]) > $signed(w.rssi)) slot_rssi[hit] = w.rssi;
               end else begin
                  slot_mask[hit] = chan_bit;
                  slot_rssi[hit] = w.rssi;
                  slot_life[hit] = reload_val;
               end
               st  = STATUS_MERGED;
               sel = hit;
            end else if (free_slot >= 0) begin
               slot_used[free_slot]   = 1'b1;
               slot_bssid[free_slot]  = w.bssid;
               slot_mask[free_slot]   = chan_bit;
               slot_rssi[free_slot]   = w.rssi;
               slot_life[free_slot]   = reload_val;
               slot_marked[free_slot] = 1'b0;
               live_entries++;
               st  = STATUS_INSERTED;
               sel = free_slot;
            end else begin
               st = STATUS_FULL;
            end
         end
         CMD_BEGIN_SWEEP: begin
            // mark entries at lifetime zero, age the rest; marks are recomputed each time
            for (int i = 0; i < TABLE_SLOTS; i++) begin
               if (!slot_used[i]) begin
                  slot_marked[i] = 1'b0;
               end else if (slot_life[i] == '0) begin
                  slot_marked[i] = 1'b1;
               end else begin
                  slot_marked[i] = 1'b0;
                  slot_life[i]   = slot_life[i] - 1'b1;
               end
            end
         end
         CMD_END_SWEEP: begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
               if (slot_used[i] && slot_marked[i]) begin
                  slot_used[i] = 1'b0;
                  live_entries--;
               end
               slot_marked[i] = 1'b0;
            end
         end
         default: begin
            r.slot_index = w.read_slot;
            if (w.read_slot < TABLE_SLOTS && slot_used[w.read_slot]) begin
               st  = STATUS_MERGED;
               sel = w.read_slot;
            end else begin
               st = STATUS_EMPTY;
            end
         end
      endcase
      r.status = st;
      if (sel >= 0) begin
         r.slot_index     = SLOT_W'(sel);
         r.entry_key      = slot_bssid[sel];
         r.entry_channels = slot_mask[sel];
         r.entry_strength = slot_rssi[sel];
         r.entry_lifetime = slot_life[sel];
      end
      r.entry_count = COUNT_W'(live_entries);
      return r;
   endfunction

   function automatic logic [KEY_W-1:0] rand_key();
      return KEY_W'({$urandom(), $urandom()});
   endfunction

   function automatic int pick_odds();
      int c;
      c = $urandom_range(0, 2);
      return (c == 0) ? 0 : (c == 1) ? 3 : 12;
   endfunction

   task automatic flag_field(string field, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch in %s: expected %0h, got %0h", field, want, got);
   endtask

   // Send one word; predict its result at the edge that accepts it.
   // Valid stays high afterwards, so the caller must either send again or drain.
   task automatic send_scan(cmd_type cmd, logic [KEY_W-1:0] key, logic [CHAN_W-1:0] chan,
                            logic signed [RSSI_W-1:0] level, logic [SLOT_W-1:0] slot);
      scan_word_type   w;
      table_reply_type want;
      w.command   = cmd;
      w.bssid     = key;
      w.channel   = chan;
      w.rssi      = level;
      w.read_slot = slot;
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.command   <= w.command;
      req_ch.bssid     <= w.bssid;
      req_ch.channel   <= w.channel;
      req_ch.rssi      <= w.rssi;
      req_ch.read_slot <= w.read_slot;
      do @(posedge clock); while (!req_ch.ready);
      want            = apply_scan_word(w);
      pending_replies = {pending_replies, want};
   endtask

   task automatic observe(logic [KEY_W-1:0] key, logic [CHAN_W-1:0] chan,
                          logic signed [RSSI_W-1:0] level);
      send_scan(CMD_OBSERVE, key, chan, level, SLOT_W'($urandom()));
   endtask

   // unused fields get random filler so every input bit toggles
   task automatic sweep(cmd_type cmd);
      send_scan(cmd, rand_key(), CHAN_W'($urandom()), RSSI_W'($urandom()), SLOT_W'($urandom()));
   endtask

   task automatic read_entry(logic [SLOT_W-1:0] slot);
      send_scan(CMD_READ, rand_key(), CHAN_W'($urandom()), RSSI_W'($urandom()), slot);
   endtask

   // Drop valid and hold until every predicted result is back, plus room for an end sweep.
   task automatic wait_replies_done();
      req_ch.valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (TABLE_SLOTS + 8) @(posedge clock);
   endtask

   // One APB transfer: setup, access until pready, then idle.
   task automatic csr_access(logic write, logic [DATA_W-1:0] wdata,
                             output logic [DATA_W-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= ADDR_W'(4 * REG_LIFETIME_RELOAD);
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_reload(logic [LIFE_W-1:0] value);
      logic [DATA_W-1:0] rd;
      wait_replies_done();
      csr_access(1'b1, DATA_W'(value), rd);
      reload_val = value;
      csr_access(1'b0, '0, rd);
      if (rd !== DATA_W'(value)) flag_field("lifetime_reload readback", 64'(value), 64'(rd));
   endtask

   // Reset value of the register, and reads of an empty table at both ends.
   task automatic test_reset_state();
      logic [DATA_W-1:0] rd;
      csr_access(1'b0, '0, rd);
      if (rd !== DATA_W'(RELOAD_RESET))
         flag_field("lifetime_reload at reset", 64'(RELOAD_RESET), 64'(rd));
      read_entry('0);
      read_entry('1);
   endtask

   // Insert at the key extremes, merge within a sweep, refresh after one.
   task automatic test_merge_and_refresh();
      observe('0, 4'd0, -8'sd128);
      observe('1, 4'd15, 8'sd127);
      observe('0, 4'd5, 8'sd127);       // merge: stronger level must not replace -128
      observe('1, 4'd10, -8'sd1);       // merge: weaker level replaces 127
      observe(48'h5555_AAAA_5555, 4'd7, 8'sd0);
      sweep(CMD_BEGIN_SWEEP);
      observe('0, 4'd9, 8'sd100);       // lifetime below reload: mask and level start over
      read_entry(5'd0);
      read_entry(5'd1);
      read_entry(5'd2);
   endtask

   // Age entries down to zero, mark, purge, and cover the two mark corner cases.
   task automatic test_sweep_purge();
      repeat (3) sweep(CMD_BEGIN_SWEEP);
      observe('1, 4'd1, 8'sd20);        // re-seen after its mark: refreshed but still purged
      sweep(CMD_END_SWEEP);
      read_entry(5'd1);
      sweep(CMD_BEGIN_SWEEP);           // slot 0 sits at lifetime zero and gets marked
      observe('0, 4'd2, -8'sd50);
      sweep(CMD_BEGIN_SWEEP);           // mark is recomputed and lost since lifetime is reloaded
      sweep(CMD_END_SWEEP);
      read_entry(5'd0);
   endtask

   // Fill every slot, overflow it, hit while full, then age everything out.
   task automatic test_table_full();
      repeat (TABLE_SLOTS + 2) observe(rand_key(), CHAN_W'($urandom()), RSSI_W'($urandom()));
      observe('0, 4'd12, -8'sd3);
      read_entry('1);
      repeat (reload_val + 1) sweep(CMD_BEGIN_SWEEP);
      sweep(CMD_END_SWEEP);
      read_entry('1);
   endtask

   // Mixed traffic over a small key pool, one phase per reload setting.
   task automatic test_random_traffic();
      logic [LIFE_W-1:0] reloads [5];
      logic [KEY_W-1:0]  key;
      int                pool_n;
      int                pick;
      reloads = '{LIFE_W'(1), LIFE_W'(15), LIFE_W'(0),
                  LIFE_W'($urandom_range(1, 15)), LIFE_W'($urandom_range(0, 15))};
      for (int p = 0; p < 5; p++) begin
         set_reload(reloads[p]);
         key_pool.delete();
         // pools larger than the table push it into the full case now and then
         pool_n = $urandom_range(8, 44);
         repeat (pool_n) key_pool = {key_pool, rand_key()};
         for (int n = 0; n < 210; n++) begin
            if (n % 40 == 0) begin
               gap_odds   = (p == 4) ? 0 : pick_odds();
               stall_odds = (p == 4) ? 0 : pick_odds();
            end
            pick = $urandom_range(0, 99);
            if (pick < 68) begin
               key = ($urandom_range(0, 9) == 0) ? rand_key()
                                                 : key_pool[$urandom_range(0, pool_n - 1)];
               observe(key, CHAN_W'($urandom()), RSSI_W'($urandom()));
            end else if (pick < 78) begin
               sweep(CMD_BEGIN_SWEEP);
            end else if (pick < 84) begin
               sweep(CMD_END_SWEEP);
            end else begin
               read_entry(SLOT_W'($urandom()));
            end
         end
      end
   endtask

   // Receiver: accept by default, stall in bursts of random length.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left   <= stall_left - 1;
         rsp_ch.ready <= (stall_left == 1);
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
         stall_left   <= $urandom_range(1, 17);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Compare each accepted result word with the oldest prediction.
   always @(posedge clock) begin
      table_reply_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result word with nothing pending: status %0d slot %0d",
                        rsp_ch.status, rsp_ch.slot_index);
         end else begin
            want = pending_replies.pop_front();
            if (rsp_ch.status !== want.status)
               flag_field("status", 64'(want.status), 64'(rsp_ch.status));
            if (rsp_ch.slot_index !== want.slot_index)
               flag_field("slot_index", 64'(want.slot_index), 64'(rsp_ch.slot_index));
            if (rsp_ch.entry_key !== want.entry_key)
               flag_field("entry_key", 64'(want.entry_key), 64'(rsp_ch.entry_key));
            if (rsp_ch.entry_channels !== want.entry_channels)
               flag_field("entry_channels", 64'(want.entry_channels),
                          64'(rsp_ch.entry_channels));
            if (rsp_ch.entry_strength !== want.entry_strength)
               flag_field("entry_strength", 64'(unsigned'(want.entry_strength)),
                          64'(unsigned'(rsp_ch.entry_strength)));
            if (rsp_ch.entry_lifetime !== want.entry_lifetime)
               flag_field("entry_lifetime", 64'(want.entry_lifetime),
                          64'(rsp_ch.entry_lifetime));
            if (rsp_ch.entry_count !== want.entry_count)
               flag_field("entry_count", 64'(want.entry_count), 64'(rsp_ch.entry_count));
         end
      end
   end

   initial begin
      // drive every input to a known value before the first edge
      req_ch.valid     = 1'b0;
      req_ch.command   = CMD_OBSERVE;
      req_ch.bssid     = '0;
      req_ch.channel   = '0;
      req_ch.rssi      = '0;
      req_ch.read_slot = '0;
      rsp_ch.ready     = 1'b0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      // empty shadow table, reload at its reset value
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         slot_used[i]   = 1'b0;
         slot_marked[i] = 1'b0;
      end
      live_entries = 0;
      reload_val   = RELOAD_RESET;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_merge_and_refresh();
      test_sweep_purge();
      test_table_full();
      test_random_traffic();

      wait_replies_done();
      if (mismatches == 0 && pending_replies.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // hang guard: far beyond the slowest legal run
   initial begin
      #10ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

@@ filelist.f @@
sv/bst_pkg.sv
sv/bst_if.sv
sv/bst_cell.sv
sv/bst_csr.sv
sv/bssid_table_with_aging.sv
test/bssid_table_with_aging_test.sv
